>>> src/dcr_pkg.sv
// ----------------------------------------------------------------------------
// DC removal package
// Shared sizes, status codes and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcr_pkg;

  localparam int MAX_SAMPLES  = 64;
  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 24;

  localparam int CFG_BITS      = 4;
  localparam int ADDR_BITS     = $clog2(MAX_SAMPLES);
  localparam int CNT_BITS      = $clog2(MAX_SAMPLES + 1);
  localparam int CH_BITS       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CHN_BITS      = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_BITS      = SAMPLE_BITS + ADDR_BITS;
  localparam int MEAN_BITS     = SAMPLE_BITS + 1;
  localparam int DIFF_BITS     = SAMPLE_BITS + 2;
  localparam int DIV_STEP_BITS = $clog2(SUM_BITS);

  localparam logic [CFG_BITS-1:0] CH_COUNT_RESET = CFG_BITS'(2);

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MISALIGNED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW   = 2'd2;

  typedef struct packed {
    logic take;
    logic clear;
    logic set_err;
    logic div_start;
    logic div_next;
    logic div_store;
    logic rd_start;
    logic rd_next;
    logic out_load;
  } dcr_cmd_t;

  typedef struct packed {
    logic misaligned;
    logic overflow;
    logic div_done;
    logic div_ch_last;
    logic emit_last;
  } dcr_stat_t;

endpackage

`default_nettype wire

>>> src/dcr_intf.sv
// ----------------------------------------------------------------------------
// DC removal channel interfaces
// Valid/ready channels for samples, results and the channel count register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dcr_in_if import dcr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface dcr_out_if import dcr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] corrected;
  logic [1:0]                    status;
  logic                          end_of_run;

  modport source (output valid, output corrected, output status, output end_of_run,
                  input ready);
  modport sink   (input valid, input corrected, input status, input end_of_run,
                  output ready);
endinterface

interface dcr_cfg_if import dcr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] chan_count;

  modport source (output valid, output chan_count, input ready);
  modport sink   (input valid, input chan_count, output ready);
endinterface

`default_nettype wire

>>> src/dcr_divider.sv
// ----------------------------------------------------------------------------
// DC removal mean divider
// Bit-serial restoring divider: signed channel sum over frame count,
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcr_divider import dcr_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic signed [SUM_BITS-1:0]  dividend,
  input  wire logic [CNT_BITS-1:0]         divisor,
  output logic                             done,
  output logic signed [MEAN_BITS-1:0]      quotient
);

  logic                     busy_r;
  logic                     done_r;
  logic [DIV_STEP_BITS-1:0] step_r;
  logic [SUM_BITS-1:0]      mag_r;
  logic [CNT_BITS-1:0]      rem_r;
  logic                     neg_r;

  logic [SUM_BITS-1:0] abs_val;
  logic [CNT_BITS:0]   trial;
  logic [CNT_BITS:0]   trial_sub;
  logic                fits;
  logic [SUM_BITS-1:0] q_full;

  assign abs_val   = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
  assign trial     = {rem_r, mag_r[SUM_BITS-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};
  assign q_full    = neg_r ? (~mag_r + SUM_BITS'(1)) : mag_r;
  assign quotient  = q_full[MEAN_BITS-1:0];
  assign done      = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= DIV_STEP_BITS'(SUM_BITS - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - DIV_STEP_BITS'(1);
        end
      end
    end
  end

  // The dividend magnitude shifts out at the top while quotient bits enter
  // at the bottom, so mag_r holds the quotient magnitude when done.
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= abs_val;
      rem_r <= '0;
      neg_r <= dividend[SUM_BITS-1];
    end else if (busy_r) begin
      mag_r <= {mag_r[SUM_BITS-2:0], fits};
      rem_r <= fits ? trial_sub[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> src/dcr_datapath.sv
// ----------------------------------------------------------------------------
// DC removal datapath
// Sample store, per-channel sums, frame counting, channel means and the
// saturating subtract that forms each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcr_datapath import dcr_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dcr_cmd_t                      cmd,
  output dcr_stat_t                          stat,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_BITS-1:0]           cfg_data,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic signed [SAMPLE_BITS-1:0]      out_corrected,
  output logic [1:0]                         out_status,
  output logic                               out_end_of_run
);

  localparam logic signed [DIFF_BITS-1:0] SAT_HI = DIFF_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [DIFF_BITS-1:0] SAT_LO = DIFF_BITS'(-(2 ** (SAMPLE_BITS - 1)));

  logic [CFG_BITS-1:0]           ch_count_r;
  logic signed [SUM_BITS-1:0]    sum_r [MAX_CHANNELS];
  logic [CNT_BITS-1:0]           count_r;
  logic [CNT_BITS-1:0]           frames_r;
  logic [CH_BITS-1:0]            cur_ch_r;
  logic                          ovf_r;
  logic [CH_BITS-1:0]            div_ch_r;
  logic signed [MEAN_BITS-1:0]   mean_r [MAX_CHANNELS];
  logic [ADDR_BITS-1:0]          emit_addr_r;
  logic [CH_BITS-1:0]            emit_ch_r;
  logic signed [SAMPLE_BITS-1:0] store_mem [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic signed [SAMPLE_BITS-1:0] corr_r;
  logic [1:0]                    status_r;
  logic                          eor_r;

  logic [CHN_BITS-1:0]          eff_ch;
  logic                         store_ok;
  logic                         cur_wrap;
  logic                         emit_wrap;
  logic [CH_BITS-1:0]           div_ch_nxt;
  logic [CH_BITS-1:0]           sum_idx;
  logic signed [SUM_BITS-1:0]   sum_sel;
  logic                         div_done;
  logic signed [MEAN_BITS-1:0]  div_q;
  logic                         rd_en;
  logic [ADDR_BITS-1:0]         rd_addr;
  logic signed [DIFF_BITS-1:0]  diff;
  logic signed [SAMPLE_BITS-1:0] sat_val;
  logic                         clear;

  // A channel count of zero acts as one, and anything above the lane count
  // acts as the lane count.
  always_comb begin
    priority if (ch_count_r == '0) begin
      eff_ch = CHN_BITS'(1);
    end else if (int'(ch_count_r) > MAX_CHANNELS) begin
      eff_ch = CHN_BITS'(MAX_CHANNELS);
    end else begin
      eff_ch = CHN_BITS'(ch_count_r);
    end
  end

  assign store_ok   = count_r < CNT_BITS'(MAX_SAMPLES);
  assign cur_wrap   = (CHN_BITS'(cur_ch_r) + CHN_BITS'(1)) >= eff_ch;
  assign emit_wrap  = (CHN_BITS'(emit_ch_r) + CHN_BITS'(1)) >= eff_ch;
  assign div_ch_nxt = cmd.div_start ? '0 : div_ch_r + CH_BITS'(1);
  assign sum_idx    = cmd.take ? cur_ch_r : div_ch_nxt;
  assign sum_sel    = sum_r[sum_idx];
  assign clear      = cmd.clear | cfg_we;
  assign rd_en      = cmd.rd_start | cmd.rd_next;
  assign rd_addr    = cmd.rd_start ? '0 : emit_addr_r + ADDR_BITS'(1);

  assign stat.misaligned  = cur_ch_r != '0;
  assign stat.overflow    = ovf_r;
  assign stat.div_done    = div_done;
  assign stat.div_ch_last = (CHN_BITS'(div_ch_r) + CHN_BITS'(1)) >= eff_ch;
  assign stat.emit_last   = (CNT_BITS'(emit_addr_r) + CNT_BITS'(1)) == count_r;

  dcr_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start | cmd.div_next),
    .dividend (sum_sel),
    .divisor  (frames_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_count_r <= CH_COUNT_RESET;
      count_r    <= '0;
      frames_r   <= '0;
      cur_ch_r   <= '0;
      ovf_r      <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sum_r[i] <= '0;
      end
    end else if (clear) begin
      if (cfg_we) begin
        ch_count_r <= cfg_data;
      end
      count_r  <= '0;
      frames_r <= '0;
      cur_ch_r <= '0;
      ovf_r    <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sum_r[i] <= '0;
      end
    end else if (cmd.take) begin
      // Once the store is full, samples only advance the channel position and set the overflow flag.
      if (store_ok) begin
        count_r          <= count_r + CNT_BITS'(1);
        sum_r[cur_ch_r]  <= sum_sel + SUM_BITS'(in_sample);
        if (cur_wrap) begin
          frames_r <= frames_r + CNT_BITS'(1);
        end
      end else begin
        ovf_r <= 1'b1;
      end
      cur_ch_r <= cur_wrap ? '0 : cur_ch_r + CH_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_ch_r    <= '0;
      emit_addr_r <= '0;
      emit_ch_r   <= '0;
    end else begin
      if (cmd.div_start || cmd.div_next) begin
        div_ch_r <= div_ch_nxt;
      end
      if (cmd.rd_start) begin
        emit_addr_r <= rd_addr;
        emit_ch_r   <= '0;
      end else if (cmd.rd_next) begin
        emit_addr_r <= rd_addr;
        emit_ch_r   <= emit_wrap ? '0 : emit_ch_r + CH_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      mean_r[div_ch_r] <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && store_ok) begin
      store_mem[count_r[ADDR_BITS-1:0]] <= in_sample;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign diff = DIFF_BITS'(rd_data_r) - DIFF_BITS'(mean_r[emit_ch_r]);

  always_comb begin
    priority if (diff > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_BITS-1:0];
    end else if (diff < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_val = diff[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_err) begin
      corr_r   <= '0;
      status_r <= stat.misaligned ? ST_MISALIGNED : ST_OVERFLOW;
      eor_r    <= 1'b1;
    end else if (cmd.out_load) begin
      corr_r   <= sat_val;
      status_r <= ST_OK;
      eor_r    <= stat.emit_last;
    end
  end

  assign out_corrected  = corr_r;
  assign out_status     = status_r;
  assign out_end_of_run = eor_r;

endmodule

`default_nettype wire

>>> src/dcr_ctrl.sv
// ----------------------------------------------------------------------------
// DC removal controller
// Sequences loading, the buffer check, the mean divisions and emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcr_ctrl import dcr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire dcr_stat_t stat,
  output dcr_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_RD    = 6'b001000,
    S_EMIT  = 6'b010000,
    S_ERR   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.misaligned || stat.overflow) begin
          cmd.set_err = 1'b1;
          state_nxt   = S_ERR;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          if (stat.div_ch_last) begin
            cmd.rd_start = 1'b1;
            state_nxt    = S_RD;
          end else begin
            cmd.div_next = 1'b1;
          end
        end
      end
      S_RD: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          // The next store read is issued in the same cycle as the transfer.
          if (stat.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      S_ERR: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/frame_mean_dc_removal_unit.sv
// ----------------------------------------------------------------------------
// Frame mean DC removal unit
// Removes the per-channel mean from one buffer of interleaved samples.
// ----------------------------------------------------------------------------
// Samples load at one per cycle until the transfer marked last, up to 64 are
// stored. A check state follows; a buffer that is not a whole number of
// frames, or that overran the store, yields a single error result. Otherwise
// each active channel's mean comes in turn from a bit-serial divider, and the
// stored samples then leave in order; each further store read is issued only
// once the previous result is taken, and each result uses the registered read
// data of the sample store. No sample is taken while a buffer is being
// processed or emitted. Writing the channel count abandons any partially loaded buffer.
`timescale 1ns / 1ps
`default_nettype none

module frame_mean_dc_removal_unit import dcr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  dcr_in_if.sink    in_bus,
  dcr_out_if.source out_bus,
  dcr_cfg_if.sink   cfg_bus
);

  dcr_cmd_t  cmd;
  dcr_stat_t stat;

  assign cfg_bus.ready = 1'b1;

  dcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_last   (in_bus.last),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dcr_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_bus.valid),
    .cfg_data       (cfg_bus.chan_count),
    .in_sample      (in_bus.sample),
    .out_corrected  (out_bus.corrected),
    .out_status     (out_bus.status),
    .out_end_of_run (out_bus.end_of_run)
  );

`ifndef SYNTH
  // Loading and emission never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_bus.ready && out_bus.valid))
    else $error("input ready while a result is offered");

  // An error result is always the sole, final result with zero data.
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.status != ST_OK) |->
      (out_bus.end_of_run && out_bus.corrected == '0))
    else $error("error result without end of run or with nonzero data");

  // The last sample of a buffer closes the input until the buffer is done.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && in_bus.last) |=> !in_bus.ready)
    else $error("input still open after last sample");
`endif

endmodule

`default_nettype wire

>>> dv/dcr_removal_checker.sv
// ----------------------------------------------------------------------------
// DC removal result checker
// Watches the sample, result and channel count channels. Keeps its own copy
// of the buffer state, works out the corrected samples or error status of
// every buffer, and compares each result transfer against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcr_removal_checker import dcr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  dcr_in_if    in_mon,
  dcr_out_if   out_mon,
  dcr_cfg_if   cfg_mon,
  output int   errors,
  output int   pending
);

  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] corrected;
    logic [1:0]                    status;
    logic                          end_of_run;
  } dc_result_t;

  logic signed [SAMPLE_BITS-1:0] buffered_samples [MAX_SAMPLES];
  longint                        channel_totals [MAX_CHANNELS];
  int unsigned                   fill_level;
  int unsigned                   channel_pos;
  bit                            store_overran;
  logic [CFG_BITS-1:0]           channels_reg;
  dc_result_t                    predicted_results [$];

  function automatic int unsigned active_channels();
    if (channels_reg == 0) return 1;
    if (channels_reg > MAX_CHANNELS) return MAX_CHANNELS;
    return channels_reg;
  endfunction

  task automatic clear_buffer();
    foreach (channel_totals[c]) channel_totals[c] = 0;
    fill_level    = 0;
    channel_pos   = 0;
    store_overran = 0;
  endtask

  task automatic push_result(input longint value, input logic [1:0] st, input logic eor);
    dc_result_t r;
    r.corrected  = value[SAMPLE_BITS-1:0];
    r.status     = st;
    r.end_of_run = eor;
    predicted_results.push_back(r);
  endtask

  // Takes one accepted sample; on the final one of the buffer it queues the
  // whole set of results the block owes for it.
  task automatic absorb_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic is_last);
    int unsigned nch;
    int unsigned pos;
    int unsigned frames;
    longint      means [MAX_CHANNELS];
    longint      diff;
    nch = active_channels();
    pos = channel_pos % nch;
    if (fill_level < MAX_SAMPLES) begin
      buffered_samples[fill_level] = smp;
      channel_totals[pos] += longint'(smp);
      fill_level++;
    end else begin
      store_overran = 1;
    end
    channel_pos = (pos + 1 >= nch) ? 0 : pos + 1;
    if (is_last) begin
      if (channel_pos != 0) begin
        push_result(0, ST_MISALIGNED, 1'b1);
      end else if (store_overran) begin
        push_result(0, ST_OVERFLOW, 1'b1);
      end else begin
        frames = fill_level / nch;
        if (frames < 1) frames = 1;
        // Signed division truncates toward zero, as the mean must.
        for (int c = 0; c < MAX_CHANNELS; c++) means[c] = channel_totals[c] / longint'(frames);
        for (int unsigned i = 0; i < fill_level; i++) begin
          diff = longint'(buffered_samples[i]) - means[i % nch];
          if (diff > SAT_HI) diff = SAT_HI;
          if (diff < SAT_LO) diff = SAT_LO;
          push_result(diff, ST_OK, (i + 1 == fill_level));
        end
      end
      clear_buffer();
    end
  endtask

  always @(posedge clk) begin
    dc_result_t exp_r;
    if (!rst_n) begin
      channels_reg = CH_COUNT_RESET;
      clear_buffer();
      predicted_results.delete();
      errors = 0;
    end else begin
      // A channel count write abandons whatever buffer was being loaded.
      if (cfg_mon.valid && cfg_mon.ready) begin
        channels_reg = cfg_mon.chan_count;
        clear_buffer();
      end
      if (in_mon.valid && in_mon.ready) absorb_sample(in_mon.sample, in_mon.last);
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result: corrected %0d status %0d end_of_run %0d",
                 out_mon.corrected, out_mon.status, out_mon.end_of_run);
          errors++;
        end else begin
          exp_r = predicted_results.pop_front();
          if (out_mon.corrected !== exp_r.corrected) begin
            $error("corrected: expected %0d, got %0d", exp_r.corrected, out_mon.corrected);
            errors++;
          end
          if (out_mon.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_mon.status);
            errors++;
          end
          if (out_mon.end_of_run !== exp_r.end_of_run) begin
            $error("end_of_run: expected %0d, got %0d", exp_r.end_of_run, out_mon.end_of_run);
            errors++;
          end
        end
      end
    end
    pending = predicted_results.size();
  end

endmodule

>>> dv/tb_frame_mean_dc_removal_unit.sv
// ----------------------------------------------------------------------------
// Frame mean DC removal unit testbench
// Drives directed and random buffers of interleaved samples through the unit
// under several channel counts and idle patterns, including a long result
// stall. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_frame_mean_dc_removal_unit;
  import dcr_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 400;
  localparam int ITEMS_PER_CFG = 24;
  localparam int SHORT_BUFFER  = 16;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk;
  logic rst_n;

  dcr_in_if  in_bus();
  dcr_out_if out_bus();
  dcr_cfg_if cfg_bus();

  int mismatch_count;
  int results_pending;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int holds_served;
  int hold_left;
  int quiet_cycles;
  int cfg_now;

  frame_mean_dc_removal_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  dcr_removal_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_bus),
    .out_mon (out_bus),
    .cfg_mon (cfg_bus),
    .errors  (mismatch_count),
    .pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    out_bus.ready = 1'b0;
    holds_served  = 0;
    hold_left     = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[frame_mean_dc_removal_unit] ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int style, input int bias);
    logic signed [SAMPLE_BITS-1:0] v;
    case (style)
      1: v = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      2: v = SAMPLE_BITS'(bias + int'($urandom_range(4096)) - 2048);
      default: begin
        case ($urandom_range(7))
          0:       v = SAMPLE_MIN;
          1:       v = SAMPLE_MAX;
          2:       v = '0;
          default: v = SAMPLE_BITS'($urandom());
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic int active_channels(input int n);
    if (n == 0) return 1;
    if (n > MAX_CHANNELS) return MAX_CHANNELS;
    return n;
  endfunction

  // Called at a clock edge; returns at the edge where the transfer happens.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic is_last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_bus.valid  <= 1'b1;
    in_bus.sample <= smp;
    in_bus.last   <= is_last;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic send_buffer(input int len, input int style);
    int bias;
    bias = int'($urandom_range(16000000)) - 8000000;
    for (int i = 0; i < len; i++) send_sample(pick_sample(style, bias), i == len - 1);
  endtask

  // Waits until every predicted result has come out, then lets the unit settle.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_channels(input int n);
    wait_idle();
    cfg_bus.valid      <= 1'b1;
    cfg_bus.chan_count <= CFG_BITS'(n);
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    cfg_now = n;
  endtask

  // Mostly whole-frame buffers; the rest are ragged or overrun the store.
  task automatic run_random(input int goal);
    int sent;
    int len;
    int nch;
    int pick;
    sent = 0;
    nch  = active_channels(cfg_now);
    while (sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        len = nch * $urandom_range(1, MAX_SAMPLES / nch);
      end else if (pick < 90) begin
        len = $urandom_range(1, MAX_SAMPLES - 1);
      end else begin
        len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 8);
      end
      // After the first buffer, stop rather than run far past the goal.
      if (sent > 0 && sent + len > goal) break;
      send_buffer(len, $urandom_range(2));
      sent += len;
    end
  endtask

  initial begin
    int cfg_plan [12];
    int send_plan [4];
    int recv_plan [4];
    cfg_plan              = '{1, 8, 0, 15, 2, 3, 5, 7, 4, 6, 9, 12};
    send_plan             = '{0, 81, 0, 29};
    recv_plan             = '{0, 0, 81, 29};
    rst_n                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.sample         = '0;
    in_bus.last           = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.chan_count    = '0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    hold_requests         = 0;
    quiet_cycles          = 0;
    cfg_now               = CH_COUNT_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed buffers at the reset channel count of two.
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    // Channel sums of -1 over two frames: the mean truncates to zero.
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    // Large opposite means drive results into both saturation limits.
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    // Three samples on two channels is not a whole number of frames.
    send_sample(SAMPLE_BITS'(5), 1'b0);
    send_sample(SAMPLE_BITS'(-5), 1'b0);
    send_sample(SAMPLE_BITS'(7), 1'b1);
    // A partly loaded buffer is dropped by the channel count write.
    send_sample(SAMPLE_BITS'(100), 1'b0);
    send_sample(SAMPLE_BITS'(-200), 1'b0);
    send_sample(SAMPLE_BITS'(300), 1'b0);
    write_channels(CH_COUNT_RESET);
    send_sample(SAMPLE_BITS'(-1), 1'b0);
    send_sample(SAMPLE_BITS'(1), 1'b1);

    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(1)) begin
          wait_idle();
          send_buffer($urandom_range(1, 5) * 2 + 1, 0);
        end
        write_channels(cfg_plan[p * 3 + k]);
        send_idle_pct  = send_plan[p];
        recv_stall_pct = recv_plan[p];
        if (p == 0 && k == 0) begin
          // Hold results back while a full buffer and then a short one are offered.
          hold_requests <= hold_requests + 1;
          send_buffer(MAX_SAMPLES, 0);
          send_buffer(SHORT_BUFFER, 1);
        end
        run_random(ITEMS_PER_CFG);
      end
    end

    wait_idle();
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("[frame_mean_dc_removal_unit] OK");
    end else begin
      $display("[frame_mean_dc_removal_unit] ERROR");
    end
    $finish;
  end

endmodule
